[design/swr_pkg.sv]
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types, sizes and codes of the square window rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

    // frame store geometry
    localparam int PLANES  = 4;
    localparam int SIDE    = 256;

    // request and response field widths
    localparam int OP_W    = 2;
    localparam int PLANE_W = 2;
    localparam int COORD_W = 8;
    localparam int PIX_W   = 8;
    localparam int ANGLE_W = 2;

    // memory addressing
    localparam int PA_W    = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int XY_W    = $clog2(SIDE);
    localparam int ADDR_W  = PA_W + 2 * XY_W;
    // window coordinates carry one spare bit for right and bottom edges
    localparam int CRD_W   = COORD_W + 1;
    localparam int CNT_W   = 2 * CRD_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_ROTATE = 2'd2;

    // angle codes
    localparam logic [ANGLE_W-1:0] ANG_NONE = 2'd0;
    localparam logic [ANGLE_W-1:0] ANG_180  = 2'd1;
    localparam logic [ANGLE_W-1:0] ANG_M90  = 2'd2;
    localparam logic [ANGLE_W-1:0] ANG_P90  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PLANE_W-1:0] plane;
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [PIX_W-1:0]   pixel_in;
        logic [COORD_W-1:0] win_left;
        logic [COORD_W-1:0] win_top;
        logic [COORD_W-1:0] win_right;
        logic [COORD_W-1:0] win_bottom;
        logic [ANGLE_W-1:0] angle;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             status;
    } t_rsp;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } t_mem_cmd;

    typedef struct packed {
        logic [PA_W-1:0]    plane;
        logic [CRD_W-1:0]   left;
        logic [CRD_W-1:0]   top;
        logic [COORD_W-1:0] span;
        logic [ANGLE_W-1:0] angle;
    } t_rot_cmd;

    function automatic logic [ADDR_W-1:0] mk_addr(
        input logic [PA_W-1:0]  pl,
        input logic [CRD_W-1:0] x,
        input logic [CRD_W-1:0] y
    );
        mk_addr = {pl, XY_W'(y), XY_W'(x)};
    endfunction

endpackage

`default_nettype wire

[design/swr_if.sv]
// ----------------------------------------------------------------------------
// swr_if
// Request and response channels: valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface swr_req_if import swr_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swr_rsp_if import swr_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/swr_ram.sv]
// ----------------------------------------------------------------------------
// swr_ram
// Single-port synchronous RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    output logic      [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

[design/swr_rot_seq.sv]
// ----------------------------------------------------------------------------
// swr_rot_seq
// Rotate sequencer: walks the window, reads a group of two (180) or four
// (90) pixels, then writes them back shifted by one place in the group.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_rot_seq import swr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_rot_cmd         i_cmd,
    input  wire logic [PIX_W-1:0] i_rdata,
    output logic                  o_busy,
    output t_mem_cmd              o_mem
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_WAIT,
        S_WRITE
    } t_state;

    t_state             r_state;
    logic [PA_W-1:0]    r_plane;
    logic [CRD_W-1:0]   r_left, r_top, r_right, r_bot;
    logic [COORD_W-1:0] r_span;
    logic               r_quad;
    logic               r_ccw;
    logic [CNT_W-2:0]   r_half, r_k;
    logic [CRD_W-1:0]   r_x, r_y;
    logic [CRD_W-1:0]   r_rt, r_rb, r_rl, r_rr, r_c;
    logic [ADDR_W-1:0]  r_addr [4];
    logic [PIX_W-1:0]   r_data [4];
    logic [1:0]         r_idx;
    logic               r_rd_pend;
    logic [1:0]         r_rd_idx;

    logic [CRD_W-1:0]   n_side;
    logic [CNT_W-1:0]   n_area;
    logic [ADDR_W-1:0]  n_grp [4];
    logic [1:0]         n_last;
    logic [1:0]         n_src;
    logic [CNT_W-2:0]   n_k;
    logic [CRD_W-1:0]   n_width;
    logic [ADDR_W-1:0]  n_pt, n_pr, n_pb, n_pw;

    always_comb begin
        n_side  = {1'b0, i_cmd.span} + CRD_W'(1);
        n_area  = n_side * n_side;
        n_last  = r_quad ? 2'd3 : 2'd1;
        n_src   = r_quad ? r_idx + 2'd1 : {1'b0, ~r_idx[0]};
        n_k     = r_k + (CNT_W-1)'(1);
        n_width = r_rr - r_rl;
        n_pt    = mk_addr(r_plane, r_rl + r_c, r_rt);
        n_pr    = mk_addr(r_plane, r_rr, r_rt + r_c);
        n_pb    = mk_addr(r_plane, r_rr - r_c, r_rb);
        n_pw    = mk_addr(r_plane, r_rl, r_rb - r_c);
        if (!r_quad) begin
            n_grp[0] = mk_addr(r_plane, r_left + r_x, r_top + r_y);
            n_grp[1] = mk_addr(r_plane, r_right - r_x, r_bot - r_y);
            n_grp[2] = n_pb;
            n_grp[3] = n_pw;
        end else if (r_ccw) begin
            n_grp[0] = n_pt;
            n_grp[1] = n_pw;
            n_grp[2] = n_pb;
            n_grp[3] = n_pr;
        end else begin
            n_grp[0] = n_pt;
            n_grp[1] = n_pr;
            n_grp[2] = n_pb;
            n_grp[3] = n_pw;
        end
    end

    always_comb begin
        o_busy      = (r_state != S_IDLE);
        o_mem.en    = (r_state == S_READ) || (r_state == S_WRITE);
        o_mem.we    = (r_state == S_WRITE);
        o_mem.addr  = r_addr[r_idx];
        o_mem.wdata = r_data[n_src];
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= r_idx;
        if (r_rd_pend) begin
            r_data[r_rd_idx] <= i_rdata;
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == S_READ);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_plane <= i_cmd.plane;
                        r_left  <= i_cmd.left;
                        r_top   <= i_cmd.top;
                        r_right <= i_cmd.left + CRD_W'(i_cmd.span);
                        r_bot   <= i_cmd.top + CRD_W'(i_cmd.span);
                        r_span  <= i_cmd.span;
                        r_quad  <= (i_cmd.angle != ANG_180);
                        r_ccw   <= (i_cmd.angle == ANG_P90);
                        r_half  <= n_area[CNT_W-1:1];
                        r_k     <= '0;
                        r_x     <= '0;
                        r_y     <= '0;
                        r_c     <= '0;
                        r_rt    <= i_cmd.top;
                        r_rb    <= i_cmd.top + CRD_W'(i_cmd.span);
                        r_rl    <= i_cmd.left;
                        r_rr    <= i_cmd.left + CRD_W'(i_cmd.span);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 4; i++) begin
                        r_addr[i] <= n_grp[i];
                    end
                    r_idx   <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_idx == n_last) begin
                        r_idx   <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_WAIT: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_idx != n_last) begin
                        r_idx <= r_idx + 2'd1;
                    end else if (!r_quad) begin
                        // pairs run in raster order over the first half
                        r_k <= n_k;
                        if (r_x == CRD_W'(r_span)) begin
                            r_x <= '0;
                            r_y <= r_y + CRD_W'(1);
                        end else begin
                            r_x <= r_x + CRD_W'(1);
                        end
                        r_state <= (n_k == r_half) ? S_IDLE : S_LOAD;
                    end else if (r_c + CRD_W'(1) < n_width) begin
                        r_c     <= r_c + CRD_W'(1);
                        r_state <= S_LOAD;
                    end else begin
                        // step one ring inward
                        r_c     <= '0;
                        r_rt    <= r_rt + CRD_W'(1);
                        r_rb    <= r_rb - CRD_W'(1);
                        r_rl    <= r_rl + CRD_W'(1);
                        r_rr    <= r_rr - CRD_W'(1);
                        r_state <= (r_rt + CRD_W'(1) < r_rb - CRD_W'(1)) ? S_LOAD : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/swr_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// swr_rsp_fifo
// Two-entry response queue between the block and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_rsp_fifo import swr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_rsp   i_push_data,
    output logic [1:0]  o_count,
    swr_rsp_if.source   o_rsp
);

    t_rsp       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       n_pop;

    assign n_pop      = o_rsp.valid && o_rsp.ready;
    assign o_rsp.valid = (r_count != 2'd0);
    assign o_rsp.data  = r_mem[r_rptr];
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (n_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, n_pop};
        end
    end

endmodule

`default_nettype wire

[design/square_window_rotator_top.sv]
// ----------------------------------------------------------------------------
// square_window_rotator_top
// Frame store of 8-bit image planes with pixel write, pixel read and
// in-place rotation of a square window.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per valid/ready handshake: op, plane, pixel
//   coordinates and value, window edges and angle. o_rsp returns exactly one
//   response per request, in order: pixel_out (read data, else zero) and
//   status (set when a rotate window was not square).
//   Writes and reads take one request per cycle while i_req.ready is high; a
//   response passes the read stage and then the response queue, the pixel
//   coming from the registered RAM read. A rotate answers at once and then
//   keeps i_req.ready low while the sequencer moves the window through the
//   single RAM port: per swapped pair (180 degrees) or group of four (+/-90
//   degrees) it loads the addresses, reads each pixel, waits, then writes.
//   A two-entry response queue lets requests keep flowing while a response
//   waits; when o_rsp.ready stays low, i_req.ready drops once the queue and
//   the read stage hold two responses between them.
//   Reset clears the control state only; pixel memory holds no defined value
//   until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module square_window_rotator_top import swr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swr_req_if.sink   i_req,
    swr_rsp_if.source o_rsp
);

    t_req               n_req;
    logic               n_accept;
    logic               n_plane_ok;
    logic               n_pix_ok;
    logic               n_w_neg, n_h_neg;
    logic [COORD_W-1:0] n_dw, n_dh, n_span;
    logic [CRD_W-1:0]   n_far_x, n_far_y;
    logic               n_in_range;
    logic               n_start;
    t_rot_cmd           n_rot;
    t_mem_cmd           n_front_mem, n_seq_mem, n_mem;
    logic [PIX_W-1:0]   n_rdata;
    logic               n_seq_busy;
    logic [1:0]         n_fifo_count;
    logic               n_pop;
    t_rsp               n_push_data;

    logic               r_s1_valid;
    logic               r_s1_read;
    logic               r_s1_status;

    assign n_req = i_req.data;
    assign n_pop = o_rsp.valid && o_rsp.ready;

    // room for the read stage once it lands in the queue
    assign i_req.ready = !n_seq_busy
                      && ({1'b0, n_fifo_count} + {2'b0, r_s1_valid} <= 3'd1 + {2'b0, n_pop});
    assign n_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_plane_ok = int'(n_req.plane) < PLANES;
        n_pix_ok   = n_plane_ok && (int'(n_req.pix_x) < SIDE) && (int'(n_req.pix_y) < SIDE);
        n_w_neg    = n_req.win_right < n_req.win_left;
        n_h_neg    = n_req.win_bottom < n_req.win_top;
        n_dw       = n_req.win_right - n_req.win_left;
        n_dh       = n_req.win_bottom - n_req.win_top;
        n_span     = (n_dw < n_dh) ? n_dw : n_dh;
        n_far_x    = {1'b0, n_req.win_left} + {1'b0, n_span};
        n_far_y    = {1'b0, n_req.win_top} + {1'b0, n_span};
        n_in_range = (int'(n_far_x) < SIDE) && (int'(n_far_y) < SIDE);
        n_start    = n_accept && (n_req.op == OP_ROTATE) && !n_w_neg && !n_h_neg
                  && n_plane_ok && n_in_range && (n_req.angle != ANG_NONE)
                  && (n_span != '0);

        n_rot.plane = PA_W'(n_req.plane);
        n_rot.left  = {1'b0, n_req.win_left};
        n_rot.top   = {1'b0, n_req.win_top};
        n_rot.span  = n_span;
        n_rot.angle = n_req.angle;

        n_front_mem.en    = n_accept && n_pix_ok
                         && ((n_req.op == OP_WRITE) || (n_req.op == OP_READ));
        n_front_mem.we    = (n_req.op == OP_WRITE);
        n_front_mem.addr  = mk_addr(PA_W'(n_req.plane), {1'b0, n_req.pix_x},
                                    {1'b0, n_req.pix_y});
        n_front_mem.wdata = n_req.pixel_in;

        n_mem = n_seq_busy ? n_seq_mem : n_front_mem;
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_s1_read   <= (n_req.op == OP_READ) && n_pix_ok;
            // signed differences of two 8-bit edges fit in nine bits
            r_s1_status <= (n_req.op == OP_ROTATE)
                        && (({1'b0, n_req.win_right} - {1'b0, n_req.win_left})
                            != ({1'b0, n_req.win_bottom} - {1'b0, n_req.win_top}));
        end
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_accept;
        end
    end

    assign n_push_data.pixel_out = r_s1_read ? n_rdata : '0;
    assign n_push_data.status    = r_s1_status;

    swr_ram #(
        .ADDR_BITS (ADDR_W),
        .DATA_BITS (PIX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (n_mem.en),
        .i_we    (n_mem.we),
        .i_addr  (n_mem.addr),
        .i_wdata (n_mem.wdata),
        .o_rdata (n_rdata)
    );

    swr_rot_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_cmd   (n_rot),
        .i_rdata (n_rdata),
        .o_busy  (n_seq_busy),
        .o_mem   (n_seq_mem)
    );

    swr_rsp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (n_push_data),
        .o_count     (n_fifo_count),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

[design/swr_checker.sv]
// ----------------------------------------------------------------------------
// swr_checker
// Port-level checks of the square window rotator.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_checker import swr_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire logic [PIX_W-1:0] i_rsp_pixel,
    input wire logic             i_rsp_status
);

    // a pending response stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_pixel) && $stable(i_rsp_status))
        else $error("stalled response changed");

    // a non-square rotate never carries pixel data
    a_status_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status |-> i_rsp_pixel == '0)
        else $error("status set with nonzero pixel");

    // reset empties the response path
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind square_window_rotator_top swr_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_pixel  (o_rsp.data.pixel_out),
    .i_rsp_status (o_rsp.data.status)
);

`default_nettype wire
